@@ hdl/text_console_writer_top_macros.svh @@
// Assertion macros used by the port-level checker of the text console writer.
`ifndef TEXT_CONSOLE_WRITER_TOP_MACROS_SVH
`define TEXT_CONSOLE_WRITER_TOP_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define TCW_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define TCW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/tcw_pkg.sv @@
// Package with opcodes, character codes, register indexes and the control state type.
package tcw_pkg;

	localparam int CELL_W = 16;

	localparam logic [1:0] OP_PUT   = 2'd0;
	localparam logic [1:0] OP_CLEAR = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

	localparam logic [1:0] CFG_COLUMNS   = 2'd0;
	localparam logic [1:0] CFG_ROWS      = 2'd1;
	localparam logic [1:0] CFG_ATTRIBUTE = 2'd2;

	localparam logic [7:0] CHAR_NEWLINE = 8'h0a;
	localparam logic [7:0] CHAR_RETURN  = 8'h0d;
	localparam logic [7:0] CHAR_BLANK   = 8'h20;

	localparam logic [7:0] RESET_COLUMNS   = 8'd80;
	localparam logic [6:0] RESET_ROWS      = 7'd25;
	localparam logic [7:0] RESET_ATTRIBUTE = 8'd7;

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_EXEC   = 6'b000010,
		S_RDWAIT = 6'b000100,
		S_SCROLL = 6'b001000,
		S_FILL   = 6'b010000,
		S_DONE   = 6'b100000
	} tcw_state_t;

endpackage

@@ hdl/tcw_frame_store.sv @@
// Character cell frame store: one write port and one registered read port.
module tcw_frame_store import tcw_pkg::*; #(
	parameter int AW = 13
) (
	input  logic              clk,
	input  logic              we,
	input  logic [AW-1:0]     waddr,
	input  logic [CELL_W-1:0] wdata,
	input  logic [AW-1:0]     raddr,
	output logic [CELL_W-1:0] rdata
);

	logic [CELL_W-1:0] mem [2**AW];
	logic [CELL_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ hdl/text_console_writer_top.sv @@
// Top level of the text console writer: cursor control, scroll and clear sequencer.
//
// Items enter on the in channel (opcode, char_code, cell_address) and each gives
// exactly one result on the out channel (cell_value, cursor_location). Registers
// columns, rows and attribute are written through cfg_wr_en, cfg_index and cfg_data;
// the user must write them only while the block is idle, the block does not enforce it.
// A put without scroll, a carriage return or an unused opcode passes S_EXEC and
// S_DONE before its result is registered; a read in range adds S_RDWAIT for the
// frame store read port. A new transaction is taken only back in S_IDLE.
// A newline, or a put in the last column, on the last row scrolls: the copy streams
// one cell per cycle through the single read and write port, then the last row is
// blanked. A clear writes columns*rows blank cells, one per cycle. The next item is
// accepted as soon as the sequencer is back at rest, even while the previous result
// waits in the output register. When the receiver stalls, a finished result holds
// in the sequencer until the output register is free.
// Reset clears the cursor and loads the register defaults. The frame store is not
// cleared; a clear item must come before cells are read.
module text_console_writer_top import tcw_pkg::*; #(
	parameter int MAX_COLUMNS = 128,
	parameter int MAX_ROWS    = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  opcode,
	input  logic [7:0]  char_code,
	input  logic [12:0] cell_address,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] cell_value,
	output logic [12:0] cursor_location
);

	localparam int DEPTH = MAX_COLUMNS * MAX_ROWS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int IW    = $clog2(DEPTH + 1);
	localparam int NCW   = $clog2(MAX_COLUMNS + 1);
	localparam int NRW   = $clog2(MAX_ROWS + 1);
	localparam int CW    = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
	localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

	tcw_state_t state_q;

	logic [7:0]  columns_q;
	logic [6:0]  rows_q;
	logic [7:0]  attribute_q;

	logic [1:0]  op_s1;
	logic [7:0]  ch_s1;
	logic [12:0] addr_s1;
	logic [NCW-1:0] nc_q;
	logic [NRW-1:0] nr_q;
	logic [IW-1:0]  total_q;
	logic [IW-1:0]  idx_q;
	logic [CW-1:0]  col_q;
	logic [RW-1:0]  row_q;
	logic [15:0]    value_q;

	logic           pipe_vld_s1;
	logic [AW-1:0]  pipe_addr_s1;

	logic           out_valid_q;
	logic [15:0]    cell_value_q;
	logic [12:0]    cursor_location_q;

	logic [NCW-1:0] nc_eff;
	logic [NRW-1:0] nr_eff;
	logic [IW-1:0]  cur_lin;
	logic [IW-1:0]  limit;
	logic           in_acc;
	logic           is_put_char;
	logic           last_col;
	logic           last_row;

	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	logic [CELL_W-1:0] mem_wdata;
	logic [AW-1:0]     mem_raddr;
	logic [CELL_W-1:0] mem_rdata;

	always_comb begin
		if (columns_q == 8'd0) begin
			nc_eff = NCW'(1);
		end else if (32'(columns_q) > 32'(MAX_COLUMNS)) begin
			nc_eff = NCW'(MAX_COLUMNS);
		end else begin
			nc_eff = NCW'(columns_q);
		end
		if (rows_q == 7'd0) begin
			nr_eff = NRW'(1);
		end else if (32'(rows_q) > 32'(MAX_ROWS)) begin
			nr_eff = NRW'(MAX_ROWS);
		end else begin
			nr_eff = NRW'(rows_q);
		end
	end

	assign in_ready    = (state_q == S_IDLE);
	assign in_acc      = in_valid && in_ready;
	assign cur_lin     = IW'(IW'(row_q) * IW'(nc_q)) + IW'(col_q);
	assign limit       = total_q - IW'(nc_q);
	assign is_put_char = (op_s1 == OP_PUT) && (ch_s1 != CHAR_NEWLINE) && (ch_s1 != CHAR_RETURN);
	assign last_col    = !((NCW'(col_q) + NCW'(1)) < nc_q);
	assign last_row    = !((NRW'(row_q) + NRW'(1)) < nr_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			columns_q   <= RESET_COLUMNS;
			rows_q      <= RESET_ROWS;
			attribute_q <= RESET_ATTRIBUTE;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_COLUMNS:   columns_q   <= cfg_data;
				CFG_ROWS:      rows_q      <= cfg_data[6:0];
				CFG_ATTRIBUTE: attribute_q <= cfg_data;
				default:       ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			col_q       <= '0;
			row_q       <= '0;
			pipe_vld_s1 <= 1'b0;
		end else begin
			pipe_vld_s1 <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (NCW'(col_q) >= nc_eff) begin
							col_q <= CW'(nc_eff - NCW'(1));
						end
						if (NRW'(row_q) >= nr_eff) begin
							row_q <= RW'(nr_eff - NRW'(1));
						end
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					state_q <= S_DONE;
					case (op_s1)
						OP_PUT: begin
							if (ch_s1 == CHAR_RETURN) begin
								col_q <= '0;
							end else if (ch_s1 == CHAR_NEWLINE || last_col) begin
								col_q <= '0;
								if (!last_row) begin
									row_q <= row_q + RW'(1);
								end else if (limit == '0) begin
									state_q <= S_FILL;
								end else begin
									state_q <= S_SCROLL;
								end
							end else begin
								col_q <= col_q + CW'(1);
							end
						end
						OP_CLEAR: begin
							col_q   <= '0;
							row_q   <= '0;
							state_q <= S_FILL;
						end
						OP_READ: begin
							if (32'(addr_s1) < 32'(DEPTH)) begin
								state_q <= S_RDWAIT;
							end
						end
						default: ;
					endcase
				end
				S_RDWAIT: begin
					state_q <= S_DONE;
				end
				S_SCROLL: begin
					if (idx_q != limit) begin
						pipe_vld_s1 <= 1'b1;
					end else begin
						state_q <= S_FILL;
					end
				end
				S_FILL: begin
					if (idx_q == total_q) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				op_s1   <= opcode;
				ch_s1   <= char_code;
				addr_s1 <= cell_address;
				nc_q    <= nc_eff;
				nr_q    <= nr_eff;
				total_q <= IW'(IW'(nc_eff) * IW'(nr_eff));
			end
			S_EXEC: begin
				value_q <= '0;
				if (op_s1 == OP_CLEAR) begin
					idx_q <= '0;
				end else if (limit == '0) begin
					idx_q <= limit;
				end else begin
					idx_q <= '0;
				end
			end
			S_RDWAIT: begin
				value_q <= mem_rdata;
			end
			S_SCROLL: begin
				if (idx_q != limit) begin
					pipe_addr_s1 <= AW'(idx_q);
					idx_q        <= idx_q + IW'(1);
				end
			end
			S_FILL: begin
				if (idx_q != total_q) begin
					idx_q <= idx_q + IW'(1);
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = AW'(cur_lin);
		mem_wdata = {attribute_q, ch_s1};
		if (pipe_vld_s1) begin
			mem_we    = 1'b1;
			mem_waddr = pipe_addr_s1;
			mem_wdata = mem_rdata;
		end else if (state_q == S_EXEC && is_put_char) begin
			mem_we    = 1'b1;
		end else if (state_q == S_FILL && idx_q != total_q) begin
			mem_we    = 1'b1;
			mem_waddr = AW'(idx_q);
			mem_wdata = {attribute_q, CHAR_BLANK};
		end
	end

	always_comb begin
		if (state_q == S_SCROLL) begin
			mem_raddr = AW'(idx_q + IW'(nc_q));
		end else begin
			mem_raddr = AW'(addr_s1);
		end
	end

	tcw_frame_store #(
		.AW(AW)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_DONE && (!out_valid_q || out_ready)) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && (!out_valid_q || out_ready)) begin
			cell_value_q      <= value_q;
			cursor_location_q <= 13'(cur_lin);
		end
	end

	assign out_valid       = out_valid_q;
	assign cell_value      = cell_value_q;
	assign cursor_location = cursor_location_q;

endmodule

@@ hdl/tcw_checker.sv @@
// Port-level checker for the text console writer and its bind to the top level.
`include "text_console_writer_top_macros.svh"

module tcw_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        cfg_wr_en,
	input logic [1:0]  cfg_index,
	input logic [7:0]  cfg_data,
	input logic        in_valid,
	input logic        in_ready,
	input logic [1:0]  opcode,
	input logic [7:0]  char_code,
	input logic [12:0] cell_address,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] cell_value,
	input logic [12:0] cursor_location
);

	logic [1:0] pending_q;
	logic       in_acc;
	logic       out_acc;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	// Count of transactions accepted on the input whose results are not yet taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 2'd0;
		end else if (in_acc && !out_acc) begin
			pending_q <= pending_q + 2'd1;
		end else if (out_acc && !in_acc) begin
			pending_q <= pending_q - 2'd1;
		end
	end

	`TCW_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid, "result dropped while stalled")
	`TCW_ASSERT_NEXT(a_out_stable, clk, arst_n, out_valid && !out_ready, $stable(cell_value) && $stable(cursor_location), "result changed while stalled")
	`TCW_ASSERT_SAME(a_no_invented, clk, arst_n, out_valid, pending_q != 2'd0, "result without an accepted transaction")
	`TCW_ASSERT_SAME(a_one_in_work, clk, arst_n, in_acc, pending_q <= 2'd1, "transaction accepted while another is in work")

endmodule

bind text_console_writer_top tcw_checker u_tcw_checker (.*);

@@ verif/text_console_writer_checker.sv @@
// Checker for the text console writer: mirrors its screen and cursor and compares every result.
module text_console_writer_checker import tcw_pkg::*; #(
	parameter int MAX_COLUMNS = 128,
	parameter int MAX_ROWS    = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [1:0]  opcode,
	input  logic [7:0]  char_code,
	input  logic [12:0] cell_address,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [15:0] cell_value,
	input  logic [12:0] cursor_location,
	output int          error_count,
	output int          outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CELL_COUNT = MAX_COLUMNS * MAX_ROWS;

	typedef struct packed {
		logic [CELL_W-1:0] cell_data;
		logic [12:0]       location;
	} console_output_t;

	logic [7:0]        columns_reg;
	logic [6:0]        rows_reg;
	logic [7:0]        attribute_reg;
	logic [CELL_W-1:0] screen_cells [CELL_COUNT];
	int unsigned       cursor_col;
	int unsigned       cursor_row;
	console_output_t   awaited_outputs [$];
	int                mismatches = 0;

	function automatic int unsigned visible_columns();
		if (columns_reg == 0) begin
			return 1;
		end
		return (columns_reg > MAX_COLUMNS) ? MAX_COLUMNS : columns_reg;
	endfunction

	function automatic int unsigned visible_rows();
		if (rows_reg == 0) begin
			return 1;
		end
		return (rows_reg > MAX_ROWS) ? MAX_ROWS : rows_reg;
	endfunction

	function automatic void write_cell(input int unsigned idx, input logic [7:0] ch);
		if (idx < CELL_COUNT) begin
			screen_cells[idx] = {attribute_reg, ch};
		end
	endfunction

	function automatic void advance_line(input int unsigned nc, input int unsigned nr);
		int unsigned i;
		cursor_col = 0;
		if (cursor_row + 1 < nr) begin
			cursor_row++;
		end else begin
			for (i = 0; i < nc * (nr - 1); i++) begin
				if (i + nc < CELL_COUNT) begin
					screen_cells[i] = screen_cells[i + nc];
				end
			end
			cursor_row = nr - 1;
			for (i = 0; i < nc; i++) begin
				write_cell(cursor_row * nc + i, CHAR_BLANK);
			end
		end
	endfunction

	function automatic console_output_t console_result(input logic [1:0] op,
			input logic [7:0] ch, input logic [12:0] addr);
		int unsigned     nc;
		int unsigned     nr;
		int unsigned     i;
		console_output_t res;
		nc = visible_columns();
		nr = visible_rows();
		res = '0;
		if (cursor_col >= nc) begin
			cursor_col = nc - 1;
		end
		if (cursor_row >= nr) begin
			cursor_row = nr - 1;
		end
		case (op)
			OP_PUT: begin
				if (ch == CHAR_NEWLINE) begin
					advance_line(nc, nr);
				end else if (ch == CHAR_RETURN) begin
					cursor_col = 0;
				end else begin
					write_cell(cursor_row * nc + cursor_col, ch);
					if (cursor_col + 1 < nc) begin
						cursor_col++;
					end else begin
						advance_line(nc, nr);
					end
				end
			end
			OP_CLEAR: begin
				cursor_col = 0;
				cursor_row = 0;
				for (i = 0; i < nc * nr; i++) begin
					write_cell(i, CHAR_BLANK);
				end
			end
			OP_READ: begin
				if (addr < CELL_COUNT) begin
					res.cell_data = screen_cells[addr];
				end
			end
			default: begin
			end
		endcase
		res.location = 13'(cursor_row * nc + cursor_col);
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		console_output_t want;
		if (!arst_n) begin
			columns_reg = RESET_COLUMNS;
			rows_reg = RESET_ROWS;
			attribute_reg = RESET_ATTRIBUTE;
			cursor_col = 0;
			cursor_row = 0;
			awaited_outputs.delete();
			foreach (screen_cells[k]) begin
				screen_cells[k] = '0;
			end
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					CFG_COLUMNS: columns_reg = cfg_data;
					CFG_ROWS: rows_reg = cfg_data[6:0];
					CFG_ATTRIBUTE: attribute_reg = cfg_data;
					default: begin
					end
				endcase
			end
			if (out_valid && out_ready) begin
				if (awaited_outputs.size() == 0) begin
					$error("Unexpected result transaction: cell_value %h, cursor_location %0d",
						cell_value, cursor_location);
					mismatches++;
				end else begin
					want = awaited_outputs.pop_front();
					if (cell_value !== want.cell_data) begin
						$error("cell_value: expected %h, actual %h", want.cell_data, cell_value);
						mismatches++;
					end
					if (cursor_location !== want.location) begin
						$error("cursor_location: expected %0d, actual %0d",
							want.location, cursor_location);
						mismatches++;
					end
				end
			end
			if (in_valid && in_ready) begin
				awaited_outputs.push_back(console_result(opcode, char_code, cell_address));
			end
		end
		error_count <= mismatches;
		outstanding <= awaited_outputs.size();
	end

endmodule

@@ verif/tb_text_console_writer_top.sv @@
// Testbench top for the text console writer: stimulus, flow control and the final verdict.
module tb_text_console_writer_top import tcw_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int         MAX_COLUMNS     = 128;
	localparam int         MAX_ROWS        = 64;
	localparam int         CYCLE_LIMIT     = 5_000_000;
	localparam int         SETTLE_CYCLES   = 8;
	localparam int         HOLD_OFF_AT     = 700;
	localparam int         HOLD_OFF_CYCLES = 400;
	localparam int         PHASE_COUNT     = 10;
	localparam logic [1:0] OP_UNUSED       = 2'd3;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [1:0]  cfg_index = CFG_COLUMNS;
	logic [7:0]  cfg_data = 8'd0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  opcode = OP_PUT;
	logic [7:0]  char_code = 8'd0;
	logic [12:0] cell_address = 13'd0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [15:0] cell_value;
	logic [12:0] cursor_location;
	int          error_count;
	int          outstanding;
	int          accepted_items = 0;
	int          burst_left = 0;
	int          screen_cols = RESET_COLUMNS;
	int          screen_rows = RESET_ROWS;
	int          cycle_count;

	text_console_writer_top #(
		.MAX_COLUMNS(MAX_COLUMNS),
		.MAX_ROWS(MAX_ROWS)
	) dut (.*);

	text_console_writer_checker #(
		.MAX_COLUMNS(MAX_COLUMNS),
		.MAX_ROWS(MAX_ROWS)
	) checker_i (.*);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	task automatic offer_item(input logic [1:0] op, input logic [7:0] ch,
			input logic [12:0] addr);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 5);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		opcode <= op;
		char_code <= ch;
		cell_address <= addr;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		accepted_items++;
	endtask

	task automatic drain_and_settle();
		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		burst_left = 0;
	endtask

	task automatic write_register(input logic [1:0] idx, input logic [7:0] value);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_screen(input logic [7:0] cols, input logic [7:0] rws,
			input logic [7:0] attr);
		drain_and_settle();
		write_register(CFG_COLUMNS, cols);
		write_register(CFG_ROWS, rws);
		write_register(CFG_ATTRIBUTE, attr);
		screen_cols = (cols == 0) ? 1 : ((cols > MAX_COLUMNS) ? MAX_COLUMNS : cols);
		screen_rows = (rws[6:0] == 0) ? 1 : ((rws[6:0] > MAX_ROWS) ? MAX_ROWS : rws[6:0]);
	endtask

	task automatic offer_random_item(input bit wide_screen);
		int          pick;
		logic [12:0] addr;
		logic [7:0]  ch;
		pick = $urandom_range(0, 99);
		addr = 13'($urandom);
		ch = 8'($urandom);
		if (pick < 55) begin
			offer_item(OP_PUT, ch, addr);
		end else if (pick < (wide_screen ? 60 : 68)) begin
			offer_item(OP_PUT, CHAR_NEWLINE, addr);
		end else if (pick < 72) begin
			offer_item(OP_PUT, CHAR_RETURN, addr);
		end else if (pick < 94) begin
			if ($urandom_range(0, 1) == 1) begin
				addr = 13'($urandom_range(0, screen_cols * screen_rows - 1));
			end
			offer_item(OP_READ, ch, addr);
		end else if (pick < 97 || wide_screen) begin
			offer_item(OP_UNUSED, ch, addr);
		end else begin
			offer_item(OP_CLEAR, ch, addr);
		end
	endtask

	initial begin : receiver
		logic [15:0] ready_mask;
		int          stretch_left;
		int          bit_pos;
		bit          held_off;
		ready_mask = '1;
		stretch_left = 0;
		bit_pos = 0;
		held_off = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (!held_off && accepted_items >= HOLD_OFF_AT) begin
				held_off = 1'b1;
				out_ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
			end else begin
				if (stretch_left == 0) begin
					stretch_left = $urandom_range(16, 160);
					case ($urandom_range(0, 3))
						0: ready_mask = '1;
						1: ready_mask = 16'($urandom | $urandom);
						2: ready_mask = 16'($urandom);
						default: ready_mask = 16'($urandom & $urandom);
					endcase
				end
				out_ready <= ready_mask[bit_pos];
				bit_pos = (bit_pos + 1) % 16;
				stretch_left--;
			end
		end
	end

	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb_text_console_writer_top: errors");
		$finish;
	end

	initial begin : stimulus
		int         phase;
		int         item_count;
		bit         wide;
		logic [7:0] cols;
		logic [7:0] rws;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// The frame store holds nothing defined yet, so only puts and an unused opcode run before the first clear.
		offer_item(OP_PUT, 8'h41, 13'h0000);
		offer_item(OP_PUT, 8'hff, 13'h1fff);
		offer_item(OP_PUT, CHAR_RETURN, 13'h0aaa);
		offer_item(OP_PUT, CHAR_NEWLINE, 13'h1555);
		offer_item(OP_PUT, 8'h00, 13'h0000);
		offer_item(OP_UNUSED, 8'h55, 13'h1fff);

		// A clear of the largest screen writes every cell of the store.
		set_screen(8'd128, 8'd64, 8'hff);
		offer_item(OP_CLEAR, 8'haa, 13'h0000);
		offer_item(OP_READ, 8'h00, 13'h0000);
		offer_item(OP_READ, 8'hff, 13'h1fff);
		offer_item(OP_PUT, 8'h7e, 13'h0000);
		offer_item(OP_PUT, CHAR_NEWLINE, 13'h0000);
		offer_item(OP_PUT, CHAR_NEWLINE, 13'h0000);
		offer_item(OP_PUT, 8'h62, 13'h0000);

		// Zero sizes act as a single cell; the cursor is pulled back inside it.
		set_screen(8'd0, 8'd0, 8'h00);
		offer_item(OP_PUT, 8'h78, 13'h0000);
		offer_item(OP_READ, 8'h00, 13'h0000);
		offer_item(OP_PUT, CHAR_NEWLINE, 13'h0000);
		offer_item(OP_READ, 8'h00, 13'd256);

		// Oversized registers act as the largest screen.
		set_screen(8'd255, 8'd127, 8'h5a);
		offer_item(OP_PUT, 8'h71, 13'h0000);
		offer_item(OP_READ, 8'h00, 13'h0000);
		offer_item(OP_PUT, CHAR_RETURN, 13'h0000);
		offer_item(OP_READ, 8'h00, 13'h1fff);

		// One column and two rows: the second put scrolls.
		set_screen(8'd1, 8'd2, 8'h81);
		offer_item(OP_CLEAR, 8'h00, 13'h0000);
		offer_item(OP_PUT, 8'h61, 13'h0000);
		offer_item(OP_PUT, 8'h63, 13'h0000);
		offer_item(OP_READ, 8'h00, 13'h0000);

		for (phase = 0; phase < PHASE_COUNT; phase++) begin
			wide = (phase == 3) || (phase == 7);
			if (phase == 3) begin
				set_screen(8'd128, 8'd64, 8'h00);
			end else if (phase == 7) begin
				set_screen(8'd255, 8'd127, 8'hff);
			end else begin
				cols = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 1))
					: 8'($urandom_range(1, 16));
				rws = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 1))
					: 8'($urandom_range(1, 8));
				set_screen(cols, rws, 8'($urandom));
			end
			item_count = wide ? 60 : 230;
			repeat (item_count) offer_random_item(wide);
		end

		drain_and_settle();
		if (error_count == 0 && outstanding == 0) begin
			$display("tb_text_console_writer_top: clean");
		end else begin
			$display("tb_text_console_writer_top: errors");
		end
		$finish;
	end

endmodule
